// ===== rtl/core/mec_pkg.sv =====
// Shared types and constants for the escape-count block.
package mec_pkg;

  localparam int C_W = 32;
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escaped;
    logic big;
  } status_t;

endpackage

// ===== rtl/core/mandelbrot_escape_count.sv =====
// Mandelbrot escape-time counter: z = z*z + c from z = 0, count steps to escape.
// Each iteration runs a registered multiply state and then an update/test state.
// The next start is taken in the cycle the result is shown; while a point is in
// progress, busy is high and the block takes no new point.
// Synchronous active-low reset: controller idles, the iteration limit returns to 255.
module mandelbrot_escape_count #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [mec_pkg::C_W-1:0]   in_c_real,
  input  logic signed [mec_pkg::C_W-1:0]   in_c_imag,
  output logic                             out_valid,
  output logic [mec_pkg::CNT_W-1:0]        out_iteration_count,
  input  logic                             cfg_we,
  input  logic [mec_pkg::CNT_W-1:0]        cfg_wdata
);

  mec_pkg::cmd_t    cmd;
  mec_pkg::status_t sts;

  mec_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mec_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .c_real    (in_c_real),
    .c_imag    (in_c_imag),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (out_valid),
    .res_count (out_iteration_count)
  );

endmodule

// ===== rtl/core/mec_ctrl.sv =====
// Controller FSM: sequences multiply and update cycles of each iteration.
module mec_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mec_pkg::status_t sts,
  output mec_pkg::cmd_t    cmd
);

  mec_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      mec_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = mec_pkg::ST_MUL;
        end
      end
      mec_pkg::ST_MUL: begin
        if (sts.limit_hit) begin
          cmd.finish = 1'b1;
          state_nxt = mec_pkg::ST_IDLE;
        end else begin
          cmd.mul = 1'b1;
          state_nxt = mec_pkg::ST_UPD;
        end
      end
      mec_pkg::ST_UPD: begin
        if (sts.escaped) begin
          cmd.finish = 1'b1;
          state_nxt = mec_pkg::ST_IDLE;
        end else begin
          // step counts even when the new point leaves the +-2 box
          cmd.step = 1'b1;
          if (sts.big) begin
            cmd.finish = 1'b1;
            state_nxt = mec_pkg::ST_IDLE;
          end else begin
            state_nxt = mec_pkg::ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = mec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mec_datapath.sv =====
// Datapath: z registers, registered products, escape tests, counter, limit reg.
module mec_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mec_pkg::cmd_t                    cmd,
  output mec_pkg::status_t                 sts,
  input  logic signed [mec_pkg::C_W-1:0]   c_real,
  input  logic signed [mec_pkg::C_W-1:0]   c_imag,
  input  logic                             cfg_we,
  input  logic [mec_pkg::CNT_W-1:0]        cfg_wdata,
  output logic                             res_valid,
  output logic [mec_pkg::CNT_W-1:0]        res_count
);

  // |x|,|y| <= 2.0 in the registers
  localparam int XW = FRAC_BITS + 3;
  localparam int PW = 2 * XW;
  // holds xx - yy + c and 2*xy + c without overflow
  localparam int W  = (((FRAC_BITS + 5) > mec_pkg::C_W) ? (FRAC_BITS + 5) : mec_pkg::C_W) + 1;

  localparam logic signed [PW-1:0] BIAS = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [W-1:0]  ESC_LIM = {{(W-FRAC_BITS-3){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};
  localparam logic signed [W-1:0]  BOX_LIM = {{(W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};

  logic signed [XW-1:0] x_r, y_r;
  logic signed [mec_pkg::C_W-1:0] cr_r, ci_r;
  logic signed [PW-1:0] pxx_r, pyy_r, pxy_r;
  logic signed [PW-1:0] pxx, pyy, pxy;
  logic [mec_pkg::CNT_W-1:0] n_r;
  logic [mec_pkg::CNT_W-1:0] max_r;
  logic valid_r;

  logic signed [PW-1:0] pxy_b;
  logic signed [W-1:0]  xx, yy, xy, sum_sq, nx, ny;

  assign pxx = PW'(x_r) * PW'(x_r);
  assign pyy = PW'(y_r) * PW'(y_r);
  assign pxy = PW'(x_r) * PW'(y_r);

  // truncate toward zero: bias negative products before the shift
  assign pxy_b  = pxy_r + $signed(BIAS & {PW{pxy_r[PW-1]}});
  assign xx     = W'(pxx_r >>> FRAC_BITS);
  assign yy     = W'(pyy_r >>> FRAC_BITS);
  assign xy     = W'(pxy_b >>> FRAC_BITS);
  assign sum_sq = xx + yy;
  assign nx     = xx - yy + W'(cr_r);
  assign ny     = (xy <<< 1) + W'(ci_r);

  assign sts.limit_hit = (n_r >= max_r);
  assign sts.escaped   = (sum_sq > ESC_LIM);
  assign sts.big       = (nx > BOX_LIM) || (nx < -BOX_LIM) ||
                         (ny > BOX_LIM) || (ny < -BOX_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= mec_pkg::MAX_ITER_RESET;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= '0;
      y_r  <= '0;
      n_r  <= '0;
      cr_r <= c_real;
      ci_r <= c_imag;
    end else if (cmd.step) begin
      x_r <= XW'(nx);
      y_r <= XW'(ny);
      n_r <= n_r + mec_pkg::CNT_W'(1);
    end
    if (cmd.mul) begin
      pxx_r <= pxx;
      pyy_r <= pyy;
      pxy_r <= pxy;
    end
  end

  assign res_valid = valid_r;
  assign res_count = n_r;

endmodule

// ===== tb/escape_count_checker.sv =====
// Checker for the escape-count block: watches both channels, predicts counts and compares.
`timescale 1ns / 1ps

module escape_count_checker #(
  parameter int FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [mec_pkg::C_W-1:0]  c_real,
  input  logic signed [mec_pkg::C_W-1:0]  c_imag,
  input  logic                            out_valid,
  input  logic [mec_pkg::CNT_W-1:0]       out_iteration_count,
  input  logic                            cfg_we,
  input  logic [mec_pkg::CNT_W-1:0]       cfg_wdata,
  output int                              error_count,
  output int                              pending_count
);

  localparam longint ESCAPE_SQ = longint'(4) <<< FRAC_BITS;
  localparam longint COMPONENT_MAX = longint'(2) <<< FRAC_BITS;

  logic [mec_pkg::CNT_W-1:0] iter_limit = mec_pkg::MAX_ITER_RESET;
  logic [mec_pkg::CNT_W-1:0] expected_counts[$];
  logic [mec_pkg::CNT_W-1:0] want;
  int mismatches = 0;

  // product truncated toward zero back to FRAC_BITS fraction bits
  function automatic longint fixmul_trunc(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] prod;
    logic neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = (ma * mb) >> FRAC_BITS;
    return neg ? -$signed(prod) : $signed(prod);
  endfunction

  function automatic logic [mec_pkg::CNT_W-1:0] predict_escape_count(
    logic signed [mec_pkg::C_W-1:0] cr,
    logic signed [mec_pkg::C_W-1:0] ci,
    logic [mec_pkg::CNT_W-1:0] limit
  );
    longint x, y, xx, yy, xy, nx, ny, cre, cie;
    int n;
    x = 0;
    y = 0;
    n = 0;
    cre = cr;
    cie = ci;
    while (n < limit) begin
      xx = fixmul_trunc(x, x);
      yy = fixmul_trunc(y, y);
      if (xx + yy > ESCAPE_SQ) break;
      xy = fixmul_trunc(x, y);
      nx = xx - yy + cre;
      ny = 2 * xy + cie;
      n++;
      // a component past 2.0 still counts the step, then escapes at once
      if (nx > COMPONENT_MAX || -nx > COMPONENT_MAX ||
          ny > COMPONENT_MAX || -ny > COMPONENT_MAX) break;
      x = nx;
      y = ny;
    end
    return n[mec_pkg::CNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      iter_limit = mec_pkg::MAX_ITER_RESET;
      expected_counts.delete();
      pending_count <= 0;
    end else begin
      if (cfg_we) iter_limit = cfg_wdata;
      if (start && !busy)
        expected_counts.push_back(predict_escape_count(c_real, c_imag, iter_limit));
      if (out_valid) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual count %0d",
                   $time, out_iteration_count);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (out_iteration_count !== want) begin
            $display("%0t: iteration_count mismatch, expected %0d, actual %0d",
                     $time, want, out_iteration_count);
            mismatches++;
          end
        end
      end
      pending_count <= expected_counts.size();
    end
    error_count <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the escape-count testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC_BITS = 28;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [31:0] SPAN_WIDE = 32'h2400_0000;  // 2.25

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [mec_pkg::C_W-1:0] in_c_real = '0;
  logic signed [mec_pkg::C_W-1:0] in_c_imag = '0;
  logic out_valid;
  logic [mec_pkg::CNT_W-1:0] out_iteration_count;
  logic cfg_we = 1'b0;
  logic [mec_pkg::CNT_W-1:0] cfg_wdata = '0;

  int error_count;
  int pending_count;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  logic [31:0] corner_vals [10] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h2000_0000, 32'hE000_0000,
    32'h2000_0001, 32'hDFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1000_0000
  };

  always #5 clk = ~clk;

  mandelbrot_escape_count #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  escape_count_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .c_real              (in_c_real),
    .c_imag              (in_c_imag),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .error_count         (error_count),
    .pending_count       (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_point(input logic [31:0] cr, input logic [31:0] ci);
    int gap;
    in_c_real <= cr;
    in_c_imag <= ci;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every outstanding transaction has returned
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [mec_pkg::CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_point(output logic [31:0] cr, output logic [31:0] ci);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      cr = $urandom;
      ci = $urandom;
    end else if (kind <= 5) begin
      cr = $urandom_range(0, 2 * SPAN_WIDE) - SPAN_WIDE;
      ci = $urandom_range(0, 2 * SPAN_WIDE) - SPAN_WIDE;
    end else if (kind <= 8) begin
      // mostly inside or near the set: re in [-2, 0.5], im in [-1.25, 1.25]
      cr = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
      ci = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
    end else begin
      cr = corner_vals[$urandom_range(0, 9)];
      ci = corner_vals[$urandom_range(0, 9)];
    end
  endtask

  task automatic run_phase(input logic [mec_pkg::CNT_W-1:0] limit, input int count);
    logic [31:0] cr, ci;
    write_limit(limit);
    repeat (count) begin
      random_point(cr, ci);
      send_point(cr, ci);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed points at the reset limit of 255
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hE000_0000, 32'h0000_0000);  // -2 sits on the boundary forever
    send_point(32'h2000_0000, 32'h0000_0000);
    send_point(32'h2000_0001, 32'h0000_0000);  // just past 2.0: large component
    send_point(32'h0000_0000, 32'hDFFF_FFFF);
    send_point(32'h0000_0000, 32'h2000_0000);  // |z|^2 lands exactly on 4
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0400_0000, 32'h0000_0000);  // cusp at 0.25
    send_point(32'h0400_0001, 32'h0000_0000);
    send_point(32'hF400_0000, 32'h0199_999A);
    send_point(32'hF000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h1000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // tiny negatives exercise truncation
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h0500_0000, 32'h0800_0000);
    drain();

    run_phase(8'd1, 50);
    run_phase(8'd0, 25);  // zero limit: no iteration runs
    run_phase(8'd255, 110);
    run_phase(8'd2, 40);
    run_phase(8'd128, 45);
    run_phase(8'($urandom_range(3, 254)), 40);
    run_phase(8'($urandom_range(3, 254)), 40);
    run_phase(8'd254, 30);

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mec_pkg.sv
rtl/core/mec_ctrl.sv
rtl/core/mec_datapath.sv
rtl/core/mandelbrot_escape_count.sv
tb/escape_count_checker.sv
tb/tb_top.sv
